// ===== sv/ssfr_pkg.sv =====
// shared types, constants and the sort network table for the sorted segmented reduce
// used by the sorter, the top level and the checker
package ssfr_pkg;

  localparam int Lanes = 8;
  localparam int ColW = 16;
  localparam int NetLen = 24;

  typedef logic [ColW-1:0] col_t;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_CONT = 2'd1;
  localparam logic [1:0] KIND_EOR  = 2'd2;

  typedef struct packed {
    logic [63:0] lane0_item;
    logic [63:0] lane1_item;
    logic [63:0] lane2_item;
    logic [63:0] lane3_item;
    logic [63:0] lane4_item;
    logic [63:0] lane5_item;
    logic [63:0] lane6_item;
    logic [63:0] lane7_item;
    logic [7:0]  valid_mask;
    logic [31:0] row_id;
    logic [1:0]  route;
    logic        end_of_row;
  } in_item_t;

  typedef struct packed {
    logic [63:0] lane0_sum;
    logic [63:0] lane1_sum;
    logic [63:0] lane2_sum;
    logic [63:0] lane3_sum;
    logic [63:0] lane4_sum;
    logic [63:0] lane5_sum;
    logic [63:0] lane6_sum;
    logic [63:0] lane7_sum;
    logic [7:0]  emit_mask;
    logic [31:0] row_out;
    logic [1:0]  route_out;
    logic [1:0]  packet_kind;
  } out_item_t;

  typedef struct packed {
    logic        vld;
    col_t        col;
    logic [31:0] bits;
  } lane_t;

  typedef struct packed {
    lane_t [Lanes-1:0] ln;
    logic [Lanes-1:0]  hd;
    logic [31:0]       row;
    logic [1:0]        route;
    logic              eor;
  } stage_t;

  localparam logic [2:0] NetA [NetLen] = '{
    3'd0, 3'd2, 3'd4, 3'd6, 3'd0, 3'd1, 3'd4, 3'd5,
    3'd0, 3'd2, 3'd4, 3'd6, 3'd0, 3'd1, 3'd2, 3'd3,
    3'd0, 3'd1, 3'd4, 3'd5, 3'd0, 3'd2, 3'd4, 3'd6};
  localparam logic [2:0] NetB [NetLen] = '{
    3'd1, 3'd3, 3'd5, 3'd7, 3'd2, 3'd3, 3'd6, 3'd7,
    3'd1, 3'd3, 3'd5, 3'd7, 3'd4, 3'd5, 3'd6, 3'd7,
    3'd2, 3'd3, 3'd6, 3'd7, 3'd1, 3'd3, 3'd5, 3'd7};
  localparam logic NetUp [NetLen] = '{
    1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
    1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1,
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};

endpackage

// ===== sv/ssfr_sorter.sv =====
// eight-lane bitonic compare-exchange network, valid lanes ascending by column
// depends on ssfr_pkg
module ssfr_sorter (
  input  ssfr_pkg::lane_t [ssfr_pkg::Lanes-1:0] lanes_i,
  output ssfr_pkg::lane_t [ssfr_pkg::Lanes-1:0] lanes_o
);

  function automatic logic precedes(ssfr_pkg::lane_t a, ssfr_pkg::lane_t b);
    if (a.vld != b.vld) return a.vld;
    return a.vld && (a.col < b.col);
  endfunction

  always_comb begin
    ssfr_pkg::lane_t [ssfr_pkg::Lanes-1:0] s;
    ssfr_pkg::lane_t a;
    ssfr_pkg::lane_t b;
    logic swap;
    s = lanes_i;
    for (int k = 0; k < ssfr_pkg::NetLen; k++) begin
      a = s[ssfr_pkg::NetA[k]];
      b = s[ssfr_pkg::NetB[k]];
      swap = ssfr_pkg::NetUp[k] ? precedes(b, a) : precedes(a, b);
      if (swap) begin
        s[ssfr_pkg::NetA[k]] = b;
        s[ssfr_pkg::NetB[k]] = a;
      end
    end
    lanes_o = s;
  end

endmodule

// ===== sv/ssfr_fadd.sv =====
// binary32 adder, round to nearest even, subnormals kept
// standalone, no package use
module ssfr_fadd (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] sum_o
);

  function automatic logic [4:0] lzc27(logic [26:0] v);
    logic [4:0] n;
    logic       hit;
    n = 5'd27;
    hit = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (v[i] && !hit) begin
        n = 5'(26 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  always_comb begin
    logic        a_nan, b_nan, a_inf, b_inf, a_big, sub, up;
    logic [31:0] x, y, res;
    logic [7:0]  ex, ey, dif;
    logic [4:0]  sh, lz, shl;
    logic [26:0] mx, my, my_s, nrm;
    logic [27:0] sum;
    logic [9:0]  e, lim, ef;
    logic [24:0] m;
    logic [22:0] fr;
    a_nan = (&a_i[30:23]) && (|a_i[22:0]);
    b_nan = (&b_i[30:23]) && (|b_i[22:0]);
    a_inf = (&a_i[30:23]) && !(|a_i[22:0]);
    b_inf = (&b_i[30:23]) && !(|b_i[22:0]);
    a_big = a_i[30:0] >= b_i[30:0];
    x = a_big ? a_i : b_i;
    y = a_big ? b_i : a_i;
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    mx = {x[30:23] != 8'd0, x[22:0], 3'b000};
    my = {y[30:23] != 8'd0, y[22:0], 3'b000};
    dif = ex - ey;
    sh = (dif > 8'd26) ? 5'd27 : dif[4:0];
    my_s = (my >> sh) | {26'd0, |(my & ~({27{1'b1}} << sh))};
    sub = x[31] ^ y[31];
    sum = sub ? ({1'b0, mx} - {1'b0, my_s}) : ({1'b0, mx} + {1'b0, my_s});
    e = {2'b00, ex};
    lz = 5'd0;
    lim = 10'd0;
    shl = 5'd0;
    if (sum[27]) begin
      nrm = {sum[27:2], sum[1] | sum[0]};
      e = e + 10'd1;
    end else begin
      lz = lzc27(sum[26:0]);
      lim = e - 10'd1;
      shl = ({5'd0, lz} > lim) ? lim[4:0] : lz;
      nrm = sum[26:0] << shl;
      e = e - {5'd0, shl};
    end
    up = nrm[2] & (nrm[1] | nrm[0] | nrm[3]);
    m = {1'b0, nrm[26:3]} + {24'd0, up};
    if (m[24]) begin
      ef = e + 10'd1;
      fr = 23'd0;
    end else begin
      ef = m[23] ? e : 10'd0;
      fr = m[22:0];
    end
    if (ef >= 10'd255) res = {x[31], 8'hff, 23'd0};
    else res = {x[31], ef[7:0], fr};
    if (sum == 28'd0) res = {(~sub) & x[31], 31'd0};
    if (a_nan) res = a_i | 32'h0040_0000;
    else if (b_nan) res = b_i | 32'h0040_0000;
    else if (a_inf && b_inf && (a_i[31] != b_i[31])) res = 32'hffc0_0000;
    else if (a_inf) res = a_i;
    else if (b_inf) res = b_i;
    sum_o = res;
  end

endmodule

// ===== sv/sorted_segmented_float_reduce8_top.sv =====
// top level: sort stage, three segmented scan levels of eight lanes, emit and slot tracking
// depends on ssfr_pkg, ssfr_sorter, ssfr_fadd
//
//   channel | signals                               | direction
//   in      | in_valid_i, in_stall_o, in_item_i     | item in
//   out     | out_valid_o, out_stall_i, out_item_o  | item out
//   cfg     | cfg_we_i, cfg_wdata_i                 | register write
//
// one item per cycle while the output is not stalled; registers st_q[0..3], then out_q
// stages: sort network, scan distance 1, 2, 4 (one adder per lane at or above the distance), emit and tracking
// the tracking slots are read and written in the output stage, in item order
// reset clears all valid bits, the slots and sets the route code to 1
// a stall on the output holds the result and backs up stage by stage
module sorted_segmented_float_reduce8_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ssfr_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ssfr_pkg::out_item_t  out_item_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_wdata_i
);

  localparam int Levels = 3;

  ssfr_pkg::lane_t [ssfr_pkg::Lanes-1:0] unp;
  ssfr_pkg::lane_t [ssfr_pkg::Lanes-1:0] srt;
  ssfr_pkg::stage_t st_d [Levels+1];
  ssfr_pkg::stage_t st_q [Levels+1];
  logic [Levels:0] v_q;
  logic [Levels:0] rdy;
  logic [31:0] scan_bits [Levels][ssfr_pkg::Lanes];
  logic        scan_hd   [Levels][ssfr_pkg::Lanes];
  logic out_rdy;
  logic out_v_q;
  ssfr_pkg::out_item_t out_d, out_q;
  logic [1:0] drc_q;
  logic [1:0] seen_q;
  logic [31:0] row_q [2];
  ssfr_pkg::col_t lastc_q [2];
  logic slot;
  logic have;
  logic cont;
  logic [ssfr_pkg::Lanes-1:0] emask;
  ssfr_pkg::col_t first_c, last_c;
  logic [63:0] sums [ssfr_pkg::Lanes];

  // unpack
  always_comb begin
    logic [63:0] it [ssfr_pkg::Lanes];
    it[0] = in_item_i.lane0_item;
    it[1] = in_item_i.lane1_item;
    it[2] = in_item_i.lane2_item;
    it[3] = in_item_i.lane3_item;
    it[4] = in_item_i.lane4_item;
    it[5] = in_item_i.lane5_item;
    it[6] = in_item_i.lane6_item;
    it[7] = in_item_i.lane7_item;
    for (int i = 0; i < ssfr_pkg::Lanes; i++) begin
      unp[i].vld  = in_item_i.valid_mask[i];
      unp[i].col  = it[i][ssfr_pkg::ColW-1:0];
      unp[i].bits = it[i][63:32];
    end
  end

  ssfr_sorter u_sorter (
    .lanes_i (unp),
    .lanes_o (srt)
  );

  always_comb begin
    st_d[0].ln    = srt;
    st_d[0].row   = in_item_i.row_id;
    st_d[0].route = in_item_i.route;
    st_d[0].eor   = in_item_i.end_of_row;
    for (int i = 0; i < ssfr_pkg::Lanes; i++) begin
      if (i == 0) st_d[0].hd[i] = 1'b1;
      else st_d[0].hd[i] = !srt[i].vld || !srt[i-1].vld || (srt[i].col != srt[i-1].col);
    end
  end

  for (genvar lv = 0; lv < Levels; lv++) begin : g_lvl
    for (genvar i = 0; i < ssfr_pkg::Lanes; i++) begin : g_lane
      if (i >= (1 << lv)) begin : g_add
        logic [31:0] s;
        logic        add;
        ssfr_fadd u_fadd (
          .a_i   (st_q[lv].ln[i].bits),
          .b_i   (st_q[lv].ln[i-(1<<lv)].bits),
          .sum_o (s)
        );
        assign add = st_q[lv].ln[i].vld & ~st_q[lv].hd[i];
        assign scan_bits[lv][i] = add ? s : st_q[lv].ln[i].bits;
        assign scan_hd[lv][i]   = add ? st_q[lv].hd[i-(1<<lv)] : st_q[lv].hd[i];
      end else begin : g_pass
        assign scan_bits[lv][i] = st_q[lv].ln[i].bits;
        assign scan_hd[lv][i]   = st_q[lv].hd[i];
      end
    end
    always_comb begin
      st_d[lv+1] = st_q[lv];
      for (int i = 0; i < ssfr_pkg::Lanes; i++) begin
        st_d[lv+1].ln[i].bits = scan_bits[lv][i];
        st_d[lv+1].hd[i]      = scan_hd[lv][i];
      end
    end
  end

  // ready chain
  assign out_rdy = !out_v_q || !out_stall_i;
  always_comb begin
    rdy[Levels] = !v_q[Levels] || out_rdy;
    for (int k = Levels - 1; k >= 0; k--) rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k <= Levels; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) st_q[0] <= st_d[0];
    for (int k = 1; k <= Levels; k++) begin
      if (rdy[k] && v_q[k-1]) st_q[k] <= st_d[k];
    end
  end

  // emit and tracking
  assign slot = (st_q[Levels].route == drc_q);

  always_comb begin
    logic endl;
    logic [31:0] b;
    emask   = '0;
    have    = 1'b0;
    first_c = '0;
    last_c  = '0;
    for (int i = 0; i < ssfr_pkg::Lanes; i++) begin
      if (i == ssfr_pkg::Lanes - 1) endl = st_q[Levels].ln[i].vld;
      else endl = st_q[Levels].ln[i].vld && (!st_q[Levels].ln[i+1].vld
                  || (st_q[Levels].ln[i].col != st_q[Levels].ln[i+1].col));
      b = st_q[Levels].ln[i].bits;
      sums[i] = '0;
      if (endl && (b[30:0] != 31'd0) && !st_q[Levels].eor) begin
        sums[i] = {b, {(32 - ssfr_pkg::ColW){1'b0}}, st_q[Levels].ln[i].col};
        emask[i] = 1'b1;
        if (!have) first_c = st_q[Levels].ln[i].col;
        have = 1'b1;
        last_c = st_q[Levels].ln[i].col;
      end
    end
    cont = have && seen_q[slot] && (row_q[slot] == st_q[Levels].row)
           && (lastc_q[slot] == first_c);
  end

  always_comb begin
    out_d.lane0_sum    = sums[0];
    out_d.lane1_sum    = sums[1];
    out_d.lane2_sum    = sums[2];
    out_d.lane3_sum    = sums[3];
    out_d.lane4_sum    = sums[4];
    out_d.lane5_sum    = sums[5];
    out_d.lane6_sum    = sums[6];
    out_d.lane7_sum    = sums[7];
    out_d.emit_mask    = emask;
    out_d.row_out      = st_q[Levels].row;
    out_d.route_out    = st_q[Levels].route;
    if (st_q[Levels].eor) out_d.packet_kind = ssfr_pkg::KIND_EOR;
    else if (cont) out_d.packet_kind = ssfr_pkg::KIND_CONT;
    else out_d.packet_kind = ssfr_pkg::KIND_DATA;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q    <= 1'b0;
      drc_q      <= 2'd1;
      seen_q     <= '0;
      row_q[0]   <= '0;
      row_q[1]   <= '0;
      lastc_q[0] <= '0;
      lastc_q[1] <= '0;
    end else begin
      if (cfg_we_i) drc_q <= cfg_wdata_i;
      if (out_rdy) begin
        out_v_q <= v_q[Levels];
        if (v_q[Levels]) begin
          if (st_q[Levels].eor) begin
            seen_q[slot] <= 1'b0;
          end else if (have) begin
            seen_q[slot]  <= 1'b1;
            row_q[slot]   <= st_q[Levels].row;
            lastc_q[slot] <= last_c;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && v_q[Levels]) out_q <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

// ===== sv/ssfr_checker.sv =====
// port-level checks on the result channel of the sorted segmented reduce
// depends on ssfr_pkg; bound to the top level
module ssfr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input ssfr_pkg::out_item_t out_item_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled item changed");

  a_eor_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.packet_kind == ssfr_pkg::KIND_EOR
    |-> out_item_o.emit_mask == 8'd0 && out_item_o.lane0_sum == 64'd0)
    else $error("end of row item carries sums");

  a_cont_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.packet_kind == ssfr_pkg::KIND_CONT
    |-> out_item_o.emit_mask != 8'd0)
    else $error("continuation with nothing emitted");

  a_lane0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.emit_mask[0] |-> out_item_o.lane0_sum == 64'd0)
    else $error("unemitted lane not zero");

endmodule

bind sorted_segmented_float_reduce8_top ssfr_checker u_ssfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
